[rtl/core/pll_divider_search_unit_defines.svh]
// Assertion macros shared by the checker of the PLL divider search unit.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef PLL_DIVIDER_SEARCH_UNIT_DEFINES_SVH
`define PLL_DIVIDER_SEARCH_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PDSU_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PDSU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/pdsu_pkg.sv]
// Shared types, widths and constants of the PLL divider search unit.
// Depends on nothing; used by the interfaces, the divider, the top level, the checker and the testbench.
package pdsu_pkg;

   localparam int unsigned OSC_FREQ_W    = 29;
   localparam int unsigned MAX_DEV_W     = 7;
   localparam int unsigned TARGET_FREQ_W = 30;
   localparam int unsigned PDIV_CODE_W   = 4;
   localparam int unsigned NDIV_CODE_W   = 7;
   localparam int unsigned K2DIV_CODE_W  = 5;
   localparam int unsigned LEAST_ERROR_W = 32;
   localparam int unsigned CSR_INDEX_W   = 1;

   localparam int unsigned P_MAX_DEF  = 16;
   localparam int unsigned K2_MAX_DEF = 28;
   localparam int unsigned N_MAX_DEF  = 128;
   localparam int unsigned DEN_W_DEF  = $clog2(P_MAX_DEF * K2_MAX_DEF + 1);

   typedef logic [OSC_FREQ_W-1:0]    osc_freq_type;
   typedef logic [MAX_DEV_W-1:0]     max_dev_type;
   typedef logic [TARGET_FREQ_W-1:0] target_freq_type;
   typedef logic [PDIV_CODE_W-1:0]   pdiv_code_type;
   typedef logic [NDIV_CODE_W-1:0]   ndiv_code_type;
   typedef logic [K2DIV_CODE_W-1:0]  k2div_code_type;
   typedef logic [LEAST_ERROR_W-1:0] least_error_type;
   typedef logic [CSR_INDEX_W-1:0]   csr_index_type;
   typedef logic [OSC_FREQ_W-1:0]    csr_data_type;

   localparam csr_index_type CSR_OSC_FREQ      = 1'd0;
   localparam csr_index_type CSR_MAX_DEV_PCT   = 1'd1;
   localparam osc_freq_type  OSC_FREQ_RESET    = 29'd20000000;
   localparam max_dev_type   MAX_DEV_PCT_RESET = 7'd2;

   localparam logic [63:0] KSTEP_FREQ   = 64'd240000000;
   localparam logic [63:0] FREF_MAX     = 64'd24000000;
   localparam logic [63:0] FREF_MIN     = 64'd8000000;
   localparam logic [63:0] FVCO_MAX     = 64'd800000000;
   localparam logic [63:0] FVCO_MIN     = 64'd400000000;
   localparam logic [63:0] PERCENT_BASE = 64'd100;

   typedef enum logic [2:0] {
      PDSU_IDLE,
      PDSU_P_CHECK,
      PDSU_K_CHECK,
      PDSU_DIVIDE,
      PDSU_N_SCAN,
      PDSU_FINISH
   } pdsu_state_type;

endpackage

[rtl/core/pdsu_if.sv]
// Valid/ready channel interfaces for requests and responses of the search unit.
// Depends on pdsu_pkg for the payload types.
interface pdsu_req_if;
   import pdsu_pkg::*;

   logic            valid;
   logic            ready;
   target_freq_type target_freq;

   modport source (output valid, output target_freq, input ready);
   modport sink (input valid, input target_freq, output ready);
endinterface

interface pdsu_rsp_if;
   import pdsu_pkg::*;

   logic            valid;
   logic            ready;
   logic            found;
   pdiv_code_type   pdiv_code;
   ndiv_code_type   ndiv_code;
   k2div_code_type  k2div_code;
   least_error_type least_error;

   modport source (output valid, output found, output pdiv_code, output ndiv_code,
                   output k2div_code, output least_error, input ready);
   modport sink (input valid, input found, input pdiv_code, input ndiv_code,
                 input k2div_code, input least_error, output ready);
endinterface

[rtl/core/pdsu_divider.sv]
// Restoring radix-2 divider, one quotient bit per cycle, for the search unit.
// Depends on pdsu_pkg for its default widths.
module pdsu_divider #(
   parameter int unsigned NUM_W = pdsu_pkg::OSC_FREQ_W,
   parameter int unsigned DEN_W = pdsu_pkg::DEN_W_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo,
   output logic [DEN_W-1:0] rem
);

   localparam int unsigned CW = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CW-1:0]    cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [DEN_W:0]   partial;
   logic             ge;
   logic [DEN_W-1:0] rem_in;

   // Bring down the next dividend bit and subtract when the divisor fits.
   always_comb begin
      partial = {rem_ff, quo_ff[NUM_W-1]};
      ge      = (partial >= {1'b0, den_ff});
      rem_in  = ge ? DEN_W'(partial - {1'b0, den_ff}) : DEN_W'(partial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[NUM_W-2:0], ge};
         rem_ff <= rem_in;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff;

endmodule

[rtl/core/pll_divider_search_unit.sv]
// Top level of the PLL divider search unit: sequencer, candidate scan and registers.
// Depends on pdsu_pkg, the channel interfaces in pdsu_if.sv and pdsu_divider.
//
// Usage: write the oscillator frequency (index 0) and the allowed deviation in
// percent (index 1) on the csr_ port while the unit is idle. Send one target
// frequency per item on req_chan; one response item per request leaves on
// rsp_chan with the chosen P, N and K2 codes and the least error in hertz.
// The unit works on one request at a time and drops req_chan.ready from the
// accepting edge until the response is written to its output register.
// The search tries each P value, visits the K2 values of each P that passes, and
// for each (P, K2) pair that passes both range checks runs the shared divider
// (osc / (P*K2)) followed by an incremental scan over N. The scan stops at an
// exact match. For the default 20 MHz oscillator only two P values pass.
// The response register holds its item while rsp_chan.ready is low; a new
// request can be taken meanwhile and waits in its final state for the slot.
// Reset is synchronous: the registers return to 20 MHz and 2 percent, the
// sequencer goes idle and any pending response is dropped.
module pll_divider_search_unit #(
   parameter int unsigned P_MAX  = pdsu_pkg::P_MAX_DEF,
   parameter int unsigned K2_MAX = pdsu_pkg::K2_MAX_DEF,
   parameter int unsigned N_MAX  = pdsu_pkg::N_MAX_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  pdsu_pkg::csr_index_type csr_index,
   input  pdsu_pkg::csr_data_type  csr_wdata,
   pdsu_req_if.sink               req_chan,
   pdsu_rsp_if.source             rsp_chan
);
   import pdsu_pkg::*;

   localparam int unsigned PW = $clog2(P_MAX + 1);
   localparam int unsigned KW = $clog2(K2_MAX + 3);
   localparam int unsigned NW = $clog2(N_MAX + 1);
   localparam int unsigned DW = $clog2(P_MAX * K2_MAX + 1);
   localparam int unsigned QW = OSC_FREQ_W + NW;

   pdsu_state_type  state_ff, state_in;

   osc_freq_type    osc_ff;
   max_dev_type     dev_ff;
   target_freq_type target_ff;
   logic            step_one_ff;
   logic [PW-1:0]   p_ff;
   logic [KW-1:0]   k2_ff;
   logic [NW-1:0]   n_ff;
   logic [DW-1:0]   d_ff;
   logic [QW-1:0]   q_ff;
   logic [DW-1:0]   r_ff;
   osc_freq_type    q0_ff;
   logic [DW-1:0]   r0_ff;
   logic [QW-1:0]   least_ff;
   logic            have_best_ff;
   pdiv_code_type   best_p_ff;
   ndiv_code_type   best_n_ff;
   k2div_code_type  best_k2_ff;

   logic            rsp_valid_ff;
   logic            rsp_found_ff;
   pdiv_code_type   rsp_pdiv_ff;
   ndiv_code_type   rsp_ndiv_ff;
   k2div_code_type  rsp_k2div_ff;
   least_error_type rsp_error_ff;

   logic            p_zero, p_ok, k2_over, fvco_ok;
   logic [63:0]     fvco;
   logic [DW-1:0]   d_w;
   logic [KW-1:0]   k2_inc;
   logic [QW-1:0]   target_q, err;
   logic            better, exact, last_n;
   logic [DW:0]     r_sum;
   logic            wrap;
   logic [63:0]     least_wide, thr_lhs, thr_rhs;
   logic            found_w;

   logic            req_ready_w, div_start, rsp_load;
   logic            div_done;
   osc_freq_type    div_quo;
   logic [DW-1:0]   div_rem;

   // ---------------------------------------------------------------
   // Candidate checks and error arithmetic
   // ---------------------------------------------------------------
   always_comb begin
      p_zero  = (p_ff == '0);
      // floor(osc / P) in [FREF_MIN, FREF_MAX] without dividing.
      p_ok    = (64'(osc_ff) >= FREF_MIN * 64'(p_ff)) &&
                (64'(osc_ff) < (FREF_MAX + 64'd1) * 64'(p_ff));
      k2_over = (k2_ff > KW'(K2_MAX));
      fvco    = 64'(target_ff) * 64'(k2_ff);
      fvco_ok = (fvco >= FVCO_MIN) && (fvco <= FVCO_MAX);
      d_w     = DW'(32'(p_ff) * 32'(k2_ff));
      k2_inc  = step_one_ff ? KW'(1) : KW'(2);

      target_q = QW'(target_ff);
      err      = (q_ff >= target_q) ? (q_ff - target_q) : (target_q - q_ff);
      better   = !have_best_ff || (err < least_ff);
      exact    = (err == '0);
      last_n   = (n_ff == NW'(N_MAX));

      // Next N adds osc/d: quotient plus remainder carry.
      r_sum = {1'b0, r_ff} + {1'b0, r0_ff};
      wrap  = (r_sum >= {1'b0, d_ff});

      // least < floor(target * dev / 100) is 100 * (least + 1) <= target * dev.
      least_wide = 64'(least_ff);
      thr_lhs    = (least_wide + 64'd1) * PERCENT_BASE;
      thr_rhs    = 64'(target_ff) * 64'(dev_ff);
      found_w    = have_best_ff && (thr_lhs <= thr_rhs);
   end

   // ---------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         PDSU_IDLE: begin
            if (req_chan.valid) state_in = PDSU_P_CHECK;
         end
         PDSU_P_CHECK: begin
            if (p_zero) state_in = PDSU_FINISH;
            else if (p_ok) state_in = PDSU_K_CHECK;
         end
         PDSU_K_CHECK: begin
            if (k2_over) state_in = PDSU_P_CHECK;
            else if (fvco_ok) state_in = PDSU_DIVIDE;
         end
         PDSU_DIVIDE: begin
            if (div_done) state_in = PDSU_N_SCAN;
         end
         PDSU_N_SCAN: begin
            if (exact) state_in = PDSU_FINISH;
            else if (last_n) state_in = PDSU_K_CHECK;
         end
         PDSU_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) state_in = PDSU_IDLE;
         end
         default: state_in = PDSU_IDLE;
      endcase
   end

   always_comb begin
      req_ready_w = 1'b0;
      div_start   = 1'b0;
      rsp_load    = 1'b0;
      case (state_ff)
         PDSU_IDLE:    req_ready_w = 1'b1;
         PDSU_K_CHECK: div_start   = !k2_over && fvco_ok;
         PDSU_FINISH:  rsp_load    = !rsp_valid_ff || rsp_chan.ready;
         default: begin
            req_ready_w = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PDSU_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         osc_ff <= OSC_FREQ_RESET;
         dev_ff <= MAX_DEV_PCT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_OSC_FREQ:    osc_ff <= csr_wdata;
            CSR_MAX_DEV_PCT: dev_ff <= csr_wdata[MAX_DEV_W-1:0];
            default:         osc_ff <= osc_ff;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Shared divider: osc / (P * K2)
   // ---------------------------------------------------------------
   pdsu_divider #(
      .NUM_W (OSC_FREQ_W),
      .DEN_W (DW)
   ) u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (osc_ff),
      .den   (d_w),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   // ---------------------------------------------------------------
   // Search datapath
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         have_best_ff <= 1'b0;
      end else if (state_ff == PDSU_IDLE && req_chan.valid) begin
         have_best_ff <= 1'b0;
      end else if (state_ff == PDSU_N_SCAN && better) begin
         have_best_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         PDSU_IDLE: begin
            if (req_chan.valid) begin
               target_ff   <= req_chan.target_freq;
               step_one_ff <= (64'(req_chan.target_freq) > KSTEP_FREQ);
               p_ff        <= PW'(P_MAX);
            end
         end
         PDSU_P_CHECK: begin
            if (!p_zero) begin
               if (p_ok) k2_ff <= KW'(1);
               else p_ff <= p_ff - PW'(1);
            end
         end
         PDSU_K_CHECK: begin
            if (k2_over) p_ff <= p_ff - PW'(1);
            else if (fvco_ok) d_ff <= d_w;
            else k2_ff <= k2_ff + k2_inc;
         end
         PDSU_DIVIDE: begin
            if (div_done) begin
               q_ff  <= QW'(div_quo);
               q0_ff <= div_quo;
               r_ff  <= div_rem;
               r0_ff <= div_rem;
               n_ff  <= NW'(1);
            end
         end
         PDSU_N_SCAN: begin
            if (better) begin
               least_ff   <= err;
               best_p_ff  <= PDIV_CODE_W'(p_ff - PW'(1));
               best_n_ff  <= NDIV_CODE_W'(n_ff - NW'(1));
               best_k2_ff <= K2DIV_CODE_W'(k2_ff - KW'(1));
            end
            if (!exact) begin
               if (last_n) begin
                  k2_ff <= k2_ff + k2_inc;
               end else begin
                  n_ff <= n_ff + NW'(1);
                  q_ff <= q_ff + QW'(q0_ff) + QW'(wrap);
                  r_ff <= wrap ? DW'(r_sum - {1'b0, d_ff}) : DW'(r_sum);
               end
            end
         end
         default: begin
            target_ff <= target_ff;
         end
      endcase
   end

   // ---------------------------------------------------------------
   // Response register
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_found_ff <= found_w;
         rsp_pdiv_ff  <= found_w ? best_p_ff : '0;
         rsp_ndiv_ff  <= found_w ? best_n_ff : '0;
         rsp_k2div_ff <= found_w ? best_k2_ff : '0;
         // No candidate or an error beyond 32 bits saturates to all ones.
         rsp_error_ff <= (!have_best_ff || (|least_wide[63:LEAST_ERROR_W])) ?
                         '1 : least_wide[LEAST_ERROR_W-1:0];
      end
   end

   assign req_chan.ready       = req_ready_w;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.found       = rsp_found_ff;
   assign rsp_chan.pdiv_code   = rsp_pdiv_ff;
   assign rsp_chan.ndiv_code   = rsp_ndiv_ff;
   assign rsp_chan.k2div_code  = rsp_k2div_ff;
   assign rsp_chan.least_error = rsp_error_ff;

endmodule

[rtl/core/pdsu_checker.sv]
// Port-level checker for the PLL divider search unit, bound to its top level.
// Depends on pdsu_pkg and on the macros in pll_divider_search_unit_defines.svh.
`include "pll_divider_search_unit_defines.svh"

module pdsu_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic                     rsp_found,
   input pdsu_pkg::pdiv_code_type   rsp_pdiv_code,
   input pdsu_pkg::ndiv_code_type   rsp_ndiv_code,
   input pdsu_pkg::k2div_code_type  rsp_k2div_code,
   input pdsu_pkg::least_error_type rsp_least_error
);
   import pdsu_pkg::*;

   // A stalled response item keeps its contents.
   `PDSU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_found) && $stable(rsp_pdiv_code) &&
         $stable(rsp_ndiv_code) && $stable(rsp_k2div_code) && $stable(rsp_least_error),
      "response item changed while stalled")

   // An accepted item blocks the next one until the search has ended.
   `PDSU_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready,
      "request accepted back to back")

   // Without a match the divider codes read zero.
   `PDSU_ASSERT_SAME(a_codes_zero, clock, reset, rsp_valid && !rsp_found,
      (rsp_pdiv_code == '0) && (rsp_ndiv_code == '0) && (rsp_k2div_code == '0),
      "nonzero codes without a match")

   // A match always comes from a real candidate, never the saturated value.
   `PDSU_ASSERT_SAME(a_found_error, clock, reset, rsp_valid && rsp_found,
      rsp_least_error != {LEAST_ERROR_W{1'b1}}, "match reported with saturated error")

endmodule

bind pll_divider_search_unit pdsu_checker u_pdsu_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_found       (rsp_chan.found),
   .rsp_pdiv_code   (rsp_chan.pdiv_code),
   .rsp_ndiv_code   (rsp_chan.ndiv_code),
   .rsp_k2div_code  (rsp_chan.k2div_code),
   .rsp_least_error (rsp_chan.least_error)
);

[test/pll_divider_search_unit_tb.sv]
// Self-checking testbench for pll_divider_search_unit: directed targets, then random ones.
// Depends on pdsu_pkg, the channel interfaces in pdsu_if.sv and the unit itself.
// Every response is compared with the typed item of its plan row or with a divider search computed here.
module pll_divider_search_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pdsu_pkg::*;

   localparam int unsigned HOLD_AT        = 30;
   localparam int unsigned HOLD_CYCLES    = 30000;
   localparam int unsigned SETTLE_CYCLES  = 16;
   localparam int unsigned RANDOM_PHASES  = 5;
   localparam int unsigned ITEMS_PER_PHASE = 16;

   typedef struct packed {
      logic            found;
      pdiv_code_type   pdiv;
      ndiv_code_type   ndiv;
      k2div_code_type  k2div;
      least_error_type err;
   } divider_pick_type;

   typedef struct packed {
      osc_freq_type     osc;
      max_dev_type      dev;
      target_freq_type  tgt;
      logic             typed;
      divider_pick_type want;
   } plan_row_type;

   localparam divider_pick_type NO_CANDIDATE = '{found: 1'b0, pdiv: '0, ndiv: '0, k2div: '0,
                                                 err: '1};

   bit   clock;
   logic reset = 1'b1;
   logic csr_we;
   csr_index_type csr_index;
   csr_data_type  csr_wdata;

   pdsu_req_if req_chan ();
   pdsu_rsp_if rsp_chan ();

   pll_divider_search_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   osc_freq_type     osc_setting;
   max_dev_type      dev_setting;
   divider_pick_type pending_picks[$];
   plan_row_type     plan[$];
   bit               quiet_run;
   bit               held;
   int unsigned      mismatches;
   int unsigned      picks_checked;
   int unsigned      targets_sent;
   int unsigned      settings_used;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Search over P, K2 and N with the current register settings, stopping at an exact match.
   function automatic divider_pick_type best_dividers(target_freq_type tgt);
      logic [63:0] t;
      logic [63:0] least;
      logic [63:0] fref;
      logic [63:0] fvco;
      logic [63:0] fout;
      logic [63:0] err;
      logic [63:0] limit;
      int unsigned step;
      int unsigned p;
      int unsigned k;
      int unsigned n;
      int unsigned bp;
      int unsigned bn;
      int unsigned bk;
      bit exact;
      divider_pick_type pick;
      t = 64'(tgt);
      least = '1;
      bp = 0;
      bn = 0;
      bk = 0;
      exact = 1'b0;
      step = (t > KSTEP_FREQ) ? 1 : 2;
      for (p = P_MAX_DEF; p >= 1 && !exact; p--) begin
         fref = 64'(osc_setting) / 64'(p);
         if (fref < FREF_MIN || fref > FREF_MAX) continue;
         for (k = 1; k <= K2_MAX_DEF && !exact; k += step) begin
            fvco = t * 64'(k);
            if (fvco < FVCO_MIN || fvco > FVCO_MAX) continue;
            for (n = 1; n <= N_MAX_DEF && !exact; n++) begin
               fout = (64'(osc_setting) * 64'(n)) / (64'(p) * 64'(k));
               err = (fout >= t) ? fout - t : t - fout;
               if (err < least) begin
                  least = err;
                  bp = p;
                  bn = n;
                  bk = k;
               end
               if (err == 0) exact = 1'b1;
            end
         end
      end
      limit = (t * 64'(dev_setting)) / PERCENT_BASE;
      pick = NO_CANDIDATE;
      if (least < limit) begin
         pick.found = 1'b1;
         pick.pdiv  = pdiv_code_type'(bp - 1);
         pick.ndiv  = ndiv_code_type'(bn - 1);
         pick.k2div = k2div_code_type'(bk - 1);
      end
      pick.err = (least > 64'hFFFF_FFFF) ? '1 : least[31:0];
      return pick;
   endfunction

   function automatic void add_row(osc_freq_type osc, max_dev_type dev, target_freq_type tgt,
                                   logic typed, divider_pick_type want);
      plan_row_type row;
      row = '{osc: osc, dev: dev, tgt: tgt, typed: typed, want: want};
      plan.push_back(row);
   endfunction

   task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      $display("mismatch in response %0d, %s: got %0d, expected %0d",
               picks_checked, what, got, want);
   endtask

   always @(posedge clock) begin
      divider_pick_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_picks.size() == 0) begin
            flag_mismatch("unexpected item", 64'(rsp_chan.least_error), 0);
         end else begin
            want = pending_picks.pop_front();
            if (rsp_chan.found !== want.found)
               flag_mismatch("found", 64'(rsp_chan.found), 64'(want.found));
            if (rsp_chan.pdiv_code !== want.pdiv)
               flag_mismatch("pdiv_code", 64'(rsp_chan.pdiv_code), 64'(want.pdiv));
            if (rsp_chan.ndiv_code !== want.ndiv)
               flag_mismatch("ndiv_code", 64'(rsp_chan.ndiv_code), 64'(want.ndiv));
            if (rsp_chan.k2div_code !== want.k2div)
               flag_mismatch("k2div_code", 64'(rsp_chan.k2div_code), 64'(want.k2div));
            if (rsp_chan.least_error !== want.err)
               flag_mismatch("least_error", 64'(rsp_chan.least_error), 64'(want.err));
         end
         picks_checked++;
      end
   end

   // Response side: random back-pressure, and one long hold-off so that a finished
   // search waits in the unit while the next target is already taken.
   initial begin
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (picks_checked == HOLD_AT && !held) begin
            held = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_chan.ready <= quiet_run || ($urandom_range(0, 99) >= 35);
         @(negedge clock);
      end
   end

   // Called at a falling edge; returns at the falling edge after the item is taken,
   // with valid still high so that a following item can go out back to back.
   task automatic offer_target(target_freq_type tgt, logic typed, divider_pick_type want);
      while (!quiet_run && $urandom_range(0, 99) < 35) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.target_freq <= tgt;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      pending_picks.push_back(typed ? want : best_dividers(tgt));
      targets_sent++;
      @(negedge clock);
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      while (pending_picks.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic apply_settings(osc_freq_type osc, max_dev_type dev);
      csr_we    <= 1'b1;
      csr_index <= CSR_OSC_FREQ;
      csr_wdata <= osc;
      @(negedge clock);
      csr_index <= CSR_MAX_DEV_PCT;
      csr_wdata <= csr_data_type'(dev);
      @(negedge clock);
      csr_we <= 1'b0;
      osc_setting = osc;
      dev_setting = dev;
      settings_used++;
   endtask

   initial begin
      plan_row_type    row;
      osc_freq_type    osc;
      max_dev_type     dev;
      target_freq_type tgt;
      logic [63:0]     guess;
      int unsigned     ph;
      int unsigned     k;
      int unsigned     roll;
      csr_we               = 1'b0;
      csr_index            = CSR_OSC_FREQ;
      csr_wdata            = '0;
      req_chan.valid       = 1'b0;
      req_chan.target_freq = '0;
      osc_setting          = OSC_FREQ_RESET;
      dev_setting          = MAX_DEV_PCT_RESET;
      settings_used        = 1;

      // Reset settings: empty target, out-of-range targets, exact matches at the top and
      // bottom of the VCO range, both sides of the K2 step boundary and two more targets.
      add_row(OSC_FREQ_RESET, MAX_DEV_PCT_RESET, 30'd0, 1'b1, NO_CANDIDATE);
      add_row(OSC_FREQ_RESET, MAX_DEV_PCT_RESET, 30'd1, 1'b1, NO_CANDIDATE);
      add_row(OSC_FREQ_RESET, MAX_DEV_PCT_RESET, 30'h3FFF_FFFF, 1'b1, NO_CANDIDATE);
      add_row(OSC_FREQ_RESET, MAX_DEV_PCT_RESET, 30'd800000000, 1'b1,
              '{1'b1, 4'd1, 7'd79, 5'd0, 32'd0});
      add_row(OSC_FREQ_RESET, MAX_DEV_PCT_RESET, 30'd400000000, 1'b1,
              '{1'b1, 4'd1, 7'd39, 5'd0, 32'd0});
      add_row(OSC_FREQ_RESET, MAX_DEV_PCT_RESET, 30'd240000000, 1'b0, NO_CANDIDATE);
      add_row(OSC_FREQ_RESET, MAX_DEV_PCT_RESET, 30'd240000001, 1'b0, NO_CANDIDATE);
      add_row(OSC_FREQ_RESET, MAX_DEV_PCT_RESET, 30'd14285715, 1'b0, NO_CANDIDATE);
      add_row(OSC_FREQ_RESET, MAX_DEV_PCT_RESET, 30'd123456789, 1'b0, NO_CANDIDATE);
      // A zero deviation never accepts, even when the search lands close.
      add_row(OSC_FREQ_RESET, 7'd0, 30'd100000000, 1'b0, NO_CANDIDATE);
      add_row(OSC_FREQ_RESET, 7'd0, 30'd400000000, 1'b0, NO_CANDIDATE);
      // Oscillators for which no pre-divider gives a legal reference.
      add_row(29'd0, 7'd2, 30'd100000000, 1'b1, NO_CANDIDATE);
      add_row(29'd1000000, 7'd2, 30'd100000000, 1'b1, NO_CANDIDATE);
      add_row(29'h1FFF_FFFF, 7'h7F, 30'd100000000, 1'b1, NO_CANDIDATE);
      add_row(29'd400000000, 7'h7F, 30'd600000000, 1'b1, NO_CANDIDATE);
      // Oscillators that leave one, several or many pre-dividers in range.
      add_row(29'd384000000, 7'd100, 30'd777777777, 1'b0, NO_CANDIDATE);
      add_row(29'd192000000, 7'h7F, 30'd28600000, 1'b0, NO_CANDIDATE);
      add_row(29'd24000000, 7'd5, 30'd333333333, 1'b0, NO_CANDIDATE);
      add_row(29'd24000000, 7'd5, 30'h2AAA_AAAA, 1'b0, NO_CANDIDATE);
      add_row(29'd12345678, 7'd1, 30'd50000000, 1'b0, NO_CANDIDATE);
      add_row(OSC_FREQ_RESET, MAX_DEV_PCT_RESET, 30'd15000000, 1'b0, NO_CANDIDATE);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[k]) begin
         row = plan[k];
         if (row.osc != osc_setting || row.dev != dev_setting) begin
            settle();
            apply_settings(row.osc, row.dev);
         end
         offer_target(row.tgt, row.typed, row.want);
      end

      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         roll = $urandom_range(0, 99);
         if (roll < 60)
            osc = osc_freq_type'($urandom_range(8000000, 200000000));
         else if (roll < 80)
            osc = osc_freq_type'($urandom_range(200000001, 400000000));
         else
            osc = osc_freq_type'($urandom());
         dev = ($urandom_range(0, 3) == 0) ? max_dev_type'($urandom())
                                           : max_dev_type'($urandom_range(1, 10));
         settle();
         apply_settings(osc, dev);
         // One phase runs with no idling on either side.
         quiet_run = (ph == 2);
         for (k = 0; k < ITEMS_PER_PHASE; k++) begin
            roll = $urandom_range(0, 99);
            // Up to 40 percent of targets are reachable outputs of some divider setting, so the
            // search can end early on an exact match.
            guess = (64'(osc_setting) * 64'($urandom_range(1, 128)))
                    / 64'($urandom_range(1, 16) * $urandom_range(1, 28));
            if (roll < 40 && guess < 64'h4000_0000)
               tgt = guess[29:0];
            else if (roll < 75)
               tgt = target_freq_type'($urandom_range(14000000, 800000000));
            else if (roll < 85)
               tgt = target_freq_type'($urandom_range(0, 14000000));
            else
               tgt = target_freq_type'($urandom());
            offer_target(tgt, 1'b0, NO_CANDIDATE);
         end
      end
      quiet_run = 1'b0;

      settle();
      repeat (50) @(negedge clock);
      $display("%0d targets searched under %0d oscillator and deviation settings;",
               targets_sent, settings_used);
      $display("%0d responses compared, %0d mismatches.", picks_checked, mismatches);
      if (mismatches == 0) begin
         $display("pll_divider_search_unit_tb: PASS");
      end else begin
         $display("pll_divider_search_unit_tb: FAIL");
      end
      $finish;
   end

   // Far beyond the slowest legal run, including the long response hold-off.
   initial begin
      #200000000;
      $display("timeout with %0d responses still outstanding", pending_picks.size());
      $display("pll_divider_search_unit_tb: FAIL");
      $finish;
   end

endmodule
